>>> sv/mmcrc_pkg.sv
`timescale 1ns / 1ps

package mmcrc_pkg;

  // Channel payload widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CNT_W      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRC_MODE     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHECK_FRAMES = 8'd1;

  // Polynomials and masks
  localparam logic [31:0] POLY_C24_MSB = 32'h00dd_d0da;
  localparam logic [31:0] POLY_C24_REF = 32'h00ad_85dd;
  localparam logic [31:0] POLY_C32_MSB = 32'h04c1_1db7;
  localparam logic [31:0] POLY_C32_REF = 32'hedb8_8320;
  localparam logic [31:0] MASK_24      = 32'h00ff_ffff;
  localparam logic [31:0] MASK_32      = 32'hffff_ffff;

  localparam logic [CNT_W-1:0] FCS_LEN_24 = 3'd3;
  localparam logic [CNT_W-1:0] FCS_LEN_32 = 3'd4;

  typedef enum logic [1:0] {
    MODE_C24_MSB = 2'd0,
    MODE_C24_REF = 2'd1,
    MODE_C32_MSB = 2'd2,
    MODE_C32_REF = 2'd3
  } crc_mode_t;

  typedef enum logic [1:0] {
    JOB_DATA     = 2'd0,
    JOB_GEN_TAIL = 2'd1,
    JOB_CHECK    = 2'd2
  } job_kind_t;

  typedef enum logic [1:0] {
    EM_STREAM = 2'd0,
    EM_FCS    = 2'd1,
    EM_CHECK  = 2'd2
  } emit_state_t;

  // Work handed from the front stage to the result stage
  typedef struct packed {
    job_kind_t         kind;
    crc_mode_t         mode;
    logic [BYTE_W-1:0] data;
    logic [CRC_W-1:0]  word;    // FCS or held bytes, first byte out in [31:24]
    logic [CRC_W-1:0]  crc;
    logic              enough;  // check: frame was at least FCS long
  } job_t;

  function automatic logic [CRC_W-1:0] init_value(crc_mode_t mode);
    return (mode == MODE_C24_MSB || mode == MODE_C24_REF) ? MASK_24 : MASK_32;
  endfunction

  function automatic logic [CNT_W-1:0] fcs_len(crc_mode_t mode);
    return (mode == MODE_C24_MSB || mode == MODE_C24_REF) ? FCS_LEN_24 : FCS_LEN_32;
  endfunction

  // One byte through the CRC, eight bit steps unrolled
  function automatic logic [CRC_W-1:0] crc_byte(crc_mode_t mode, logic [CRC_W-1:0] crc,
                                                 logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc;
    unique case (mode)
      MODE_C24_MSB: begin
        c = c ^ {8'h00, b, 16'h0000};
        for (int i = 0; i < 8; i++)
          c = c[23] ? (((c << 1) ^ POLY_C24_MSB) & MASK_24) : ((c << 1) & MASK_24);
      end
      MODE_C24_REF: begin
        c = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
          c = c[0] ? ((c >> 1) ^ POLY_C24_REF) : (c >> 1);
        c = c & MASK_24;
      end
      MODE_C32_MSB: begin
        c = c ^ {b, 24'h0};
        for (int i = 0; i < 8; i++)
          c = c[31] ? ((c << 1) ^ POLY_C32_MSB) : (c << 1);
      end
      default: begin
        c = c ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
          c = c[0] ? ((c >> 1) ^ POLY_C32_REF) : (c >> 1);
      end
    endcase
    return c;
  endfunction

endpackage

>>> sv/mmcrc_in_if.sv
`timescale 1ns / 1ps

interface mmcrc_in_if;
  logic                          valid;
  logic                          ready;
  logic [mmcrc_pkg::BYTE_W-1:0]  data_byte;
  logic                          last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> sv/mmcrc_out_if.sv
`timescale 1ns / 1ps

interface mmcrc_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmcrc_pkg::BYTE_W-1:0]  out_byte;
  logic                          out_last;
  logic                          check_done;
  logic                          check_ok;

  modport source (output valid, output out_byte, output out_last, output check_done,
                  output check_ok, input ready);
  modport sink   (input valid, input out_byte, input out_last, input check_done,
                  input check_ok, output ready);
endinterface

>>> sv/mmcrc_cfg_if.sv
`timescale 1ns / 1ps

interface mmcrc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [mmcrc_pkg::CFG_IDX_W-1:0]   index;
  logic [mmcrc_pkg::CFG_DATA_W-1:0]  wdata;

  modport source (output valid, output index, output wdata, input ready);
  modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> sv/mmcrc_front.sv
`timescale 1ns / 1ps

module mmcrc_front (
  input  logic              clk,
  input  logic              rst,
  mmcrc_in_if.sink          in_chan,
  mmcrc_cfg_if.sink         cfg_chan,
  output logic              job_valid,
  output mmcrc_pkg::job_t   job,
  input  logic              job_take
);

  mmcrc_pkg::crc_mode_t                 crc_mode;
  logic                                 check_frames;
  logic [mmcrc_pkg::CRC_W-1:0]          crc_reg;
  logic [mmcrc_pkg::BYTE_W-1:0]         held [4];
  logic [mmcrc_pkg::CNT_W-1:0]          held_count;

  logic                                 accept;
  logic                                 cfg_write;
  logic [mmcrc_pkg::CNT_W-1:0]          w;
  logic [mmcrc_pkg::CRC_W-1:0]          init;
  logic [mmcrc_pkg::CRC_W-1:0]          crc_gen;
  logic [mmcrc_pkg::CRC_W-1:0]          crc_chk;
  logic [mmcrc_pkg::CRC_W-1:0]          fcs;
  logic [mmcrc_pkg::CRC_W-1:0]          fcs_word;
  logic                                 full;
  logic [mmcrc_pkg::BYTE_W-1:0]         held_next [4];
  logic [mmcrc_pkg::CNT_W-1:0]          count_upd;
  logic [mmcrc_pkg::CRC_W-1:0]          crc_next;
  logic                                 produce;
  mmcrc_pkg::job_t                      job_next;
  mmcrc_pkg::crc_mode_t                 new_mode;

  assign accept    = in_chan.valid && in_chan.ready;
  assign cfg_write = cfg_chan.valid && cfg_chan.ready;
  assign in_chan.ready  = !job_valid || job_take;
  assign cfg_chan.ready = 1'b1;

  assign w    = mmcrc_pkg::fcs_len(crc_mode);
  assign init = mmcrc_pkg::init_value(crc_mode);
  assign new_mode = mmcrc_pkg::crc_mode_t'(cfg_chan.wdata[1:0]);

  // Generate path: CRC over the byte, then FCS laid out first byte on top
  always_comb begin
    crc_gen = mmcrc_pkg::crc_byte(crc_mode, crc_reg, in_chan.data_byte);
    fcs = (crc_mode == mmcrc_pkg::MODE_C32_MSB) ? crc_gen : (~crc_gen & init);
    case (crc_mode)
      mmcrc_pkg::MODE_C24_MSB: fcs_word = fcs << 8;
      mmcrc_pkg::MODE_C32_MSB: fcs_word = fcs;
      default:                 fcs_word = {fcs[7:0], fcs[15:8], fcs[23:16], fcs[31:24]};
    endcase
  end

  // Check path: once the hold line is full, the oldest byte enters the CRC
  always_comb begin
    full    = (held_count >= w);
    crc_chk = mmcrc_pkg::crc_byte(crc_mode, crc_reg, held[0]);
    for (int i = 0; i < 4; i++)
      held_next[i] = held[i];
    count_upd = held_count;
    if (full) begin
      held_next[0] = held[1];
      held_next[1] = held[2];
      if (w == mmcrc_pkg::FCS_LEN_32) begin
        held_next[2] = held[3];
        held_next[3] = in_chan.data_byte;
      end else begin
        held_next[2] = in_chan.data_byte;
      end
    end else begin
      held_next[held_count[1:0]] = in_chan.data_byte;
      count_upd = held_count + 3'd1;
    end
  end

  // Next CRC and the job for the result stage
  always_comb begin
    produce  = 1'b0;
    crc_next = crc_reg;
    job_next = job;
    if (!check_frames) begin
      produce       = 1'b1;
      crc_next      = in_chan.last_byte ? init : crc_gen;
      job_next.kind = in_chan.last_byte ? mmcrc_pkg::JOB_GEN_TAIL : mmcrc_pkg::JOB_DATA;
      job_next.data = in_chan.data_byte;
      job_next.word = fcs_word;
    end else begin
      produce         = in_chan.last_byte;
      crc_next        = in_chan.last_byte ? init : (full ? crc_chk : crc_reg);
      job_next.kind   = mmcrc_pkg::JOB_CHECK;
      job_next.data   = '0;
      job_next.crc    = full ? crc_chk : crc_reg;
      job_next.word   = {held_next[0], held_next[1], held_next[2], held_next[3]};
      job_next.enough = (count_upd >= w);
    end
    job_next.mode = crc_mode;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_mode     <= mmcrc_pkg::MODE_C32_REF;
      check_frames <= 1'b0;
      crc_reg      <= mmcrc_pkg::init_value(mmcrc_pkg::MODE_C32_REF);
      held_count   <= '0;
      job_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_chan.index)
          mmcrc_pkg::REG_CRC_MODE: begin
            crc_mode   <= new_mode;
            crc_reg    <= mmcrc_pkg::init_value(new_mode);
            held_count <= '0;
          end
          mmcrc_pkg::REG_CHECK_FRAMES: begin
            check_frames <= cfg_chan.wdata[0];
            crc_reg      <= init;
            held_count   <= '0;
          end
          default: ;
        endcase
      end else if (accept) begin
        crc_reg <= crc_next;
        if (check_frames && !in_chan.last_byte)
          held_count <= count_upd;
        else
          held_count <= '0;
      end
      if (accept && produce)
        job_valid <= 1'b1;
      else if (job_take)
        job_valid <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept && check_frames) begin
      for (int i = 0; i < 4; i++)
        held[i] <= held_next[i];
    end
    if (accept && produce)
      job <= job_next;
  end

  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= w)
    else $error("hold line count beyond FCS length");

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    accept && in_chan.last_byte && !cfg_write |=> crc_reg == init && held_count == '0)
    else $error("CRC not restarted after last byte");

endmodule

>>> sv/mmcrc_emit.sv
`timescale 1ns / 1ps

module mmcrc_emit (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  mmcrc_pkg::job_t   job,
  output logic              job_take,
  mmcrc_out_if.source       out_chan
);

  mmcrc_pkg::emit_state_t          state;
  mmcrc_pkg::emit_state_t          state_next;
  logic                            o_valid;
  logic [mmcrc_pkg::BYTE_W-1:0]    o_byte;
  logic                            o_last;
  logic                            o_done;
  logic                            o_ok;
  logic [mmcrc_pkg::CNT_W-1:0]     cnt;
  logic [mmcrc_pkg::CRC_W-1:0]     word;
  logic [mmcrc_pkg::CRC_W-1:0]     crc;
  mmcrc_pkg::crc_mode_t            mode;
  logic                            comp;

  logic                            o_valid_next;
  logic [mmcrc_pkg::BYTE_W-1:0]    o_byte_next;
  logic                            o_last_next;
  logic                            o_done_next;
  logic                            o_ok_next;
  logic [mmcrc_pkg::CNT_W-1:0]     cnt_next;
  logic [mmcrc_pkg::CRC_W-1:0]     word_next;
  logic [mmcrc_pkg::CRC_W-1:0]     crc_next;
  mmcrc_pkg::crc_mode_t            mode_next;
  logic                            comp_next;

  logic                            out_free;
  logic [mmcrc_pkg::BYTE_W-1:0]    chk_byte;
  logic [mmcrc_pkg::CRC_W-1:0]     chk_crc;

  assign out_free = !o_valid || out_chan.ready;
  assign job_take = job_valid && (state == mmcrc_pkg::EM_STREAM) && out_free;
  assign chk_byte = word[31:24] ^ {mmcrc_pkg::BYTE_W{comp}};
  assign chk_crc  = mmcrc_pkg::crc_byte(mode, crc, chk_byte);

  assign out_chan.valid      = o_valid;
  assign out_chan.out_byte   = o_byte;
  assign out_chan.out_last   = o_last;
  assign out_chan.check_done = o_done;
  assign out_chan.check_ok   = o_ok;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      mmcrc_pkg::EM_STREAM: begin
        if (job_take && job.kind == mmcrc_pkg::JOB_GEN_TAIL)
          state_next = mmcrc_pkg::EM_FCS;
        else if (job_take && job.kind == mmcrc_pkg::JOB_CHECK && job.enough)
          state_next = mmcrc_pkg::EM_CHECK;
      end
      mmcrc_pkg::EM_FCS, mmcrc_pkg::EM_CHECK: begin
        if (out_free && cnt == 3'd1)
          state_next = mmcrc_pkg::EM_STREAM;
      end
      default: state_next = mmcrc_pkg::EM_STREAM;
    endcase
  end

  // Result register and sequencer datapath
  always_comb begin
    o_valid_next = o_valid && !out_chan.ready;
    o_byte_next  = o_byte;
    o_last_next  = o_last;
    o_done_next  = o_done;
    o_ok_next    = o_ok;
    cnt_next     = cnt;
    word_next    = word;
    crc_next     = crc;
    mode_next    = mode;
    comp_next    = comp;
    unique case (state)
      mmcrc_pkg::EM_STREAM: begin
        if (job_take) begin
          case (job.kind)
            mmcrc_pkg::JOB_CHECK: begin
              if (job.enough) begin
                cnt_next  = mmcrc_pkg::fcs_len(job.mode);
                word_next = job.word;
                crc_next  = job.crc;
                mode_next = job.mode;
                comp_next = (job.mode != mmcrc_pkg::MODE_C32_MSB);
              end else begin
                // frame shorter than its FCS fails outright
                o_valid_next = 1'b1;
                o_byte_next  = '0;
                o_last_next  = 1'b1;
                o_done_next  = 1'b1;
                o_ok_next    = 1'b0;
              end
            end
            default: begin
              o_valid_next = 1'b1;
              o_byte_next  = job.data;
              o_last_next  = 1'b0;
              o_done_next  = 1'b0;
              o_ok_next    = 1'b0;
              if (job.kind == mmcrc_pkg::JOB_GEN_TAIL) begin
                cnt_next  = mmcrc_pkg::fcs_len(job.mode);
                word_next = job.word;
              end
            end
          endcase
        end
      end
      mmcrc_pkg::EM_FCS: begin
        if (out_free) begin
          o_valid_next = 1'b1;
          o_byte_next  = word[31:24];
          o_last_next  = (cnt == 3'd1);
          o_done_next  = 1'b0;
          o_ok_next    = 1'b0;
          word_next    = word << 8;
          cnt_next     = cnt - 3'd1;
        end
      end
      mmcrc_pkg::EM_CHECK: begin
        if (cnt != 3'd1) begin
          crc_next  = chk_crc;
          word_next = word << 8;
          cnt_next  = cnt - 3'd1;
        end else if (out_free) begin
          o_valid_next = 1'b1;
          o_byte_next  = '0;
          o_last_next  = 1'b1;
          o_done_next  = 1'b1;
          o_ok_next    = (chk_crc == '0);
          cnt_next     = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mmcrc_pkg::EM_STREAM;
      o_valid <= 1'b0;
      cnt     <= '0;
    end else begin
      state   <= state_next;
      o_valid <= o_valid_next;
      cnt     <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    o_byte <= o_byte_next;
    o_last <= o_last_next;
    o_done <= o_done_next;
    o_ok   <= o_ok_next;
    word   <= word_next;
    crc    <= crc_next;
    mode   <= mode_next;
    comp   <= comp_next;
  end

  a_seq_count: assert property (@(posedge clk) disable iff (rst)
    state != mmcrc_pkg::EM_STREAM |-> cnt != '0)
    else $error("sequencer active with no bytes left");

  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    o_valid && o_done |-> o_last && o_byte == '0)
    else $error("verdict result not marked last");

  a_tail_start: assert property (@(posedge clk) disable iff (rst)
    job_take && job.kind == mmcrc_pkg::JOB_GEN_TAIL |=> state == mmcrc_pkg::EM_FCS)
    else $error("FCS append did not start");

endmodule

>>> sv/multi_mode_crc_fcs_engine.sv
`timescale 1ns / 1ps

// Channel   Dir  Payload                                     Accepted when
// in_chan   in   data_byte[7:0], last_byte                   valid && ready
// out_chan  out  out_byte[7:0], out_last, check_done, check_ok valid && ready
// cfg_chan  in   index[7:0] (0 crc_mode, 1 check_frames), wdata[7:0] valid (ready tied high)
//
// A data byte passes two registers: the 8-bit CRC update runs between the input
// handshake and the job register, and the job then loads the result register.
// Sustained rate is one byte per cycle while the output is not stalled; at each frame
// end the FCS sequencer holds the input (generate: one appended byte per cycle;
// check: one held byte through the CRC per cycle, verdict with the last).
// rst is synchronous: mode crc32 reflected, generate, CRC all ones, no hold.
// Output stalls back up through the job register into in_chan.ready.

module multi_mode_crc_fcs_engine (
  input  logic          clk,
  input  logic          rst,
  mmcrc_in_if.sink      in_chan,
  mmcrc_out_if.source   out_chan,
  mmcrc_cfg_if.sink     cfg_chan
);

  logic             job_valid;
  logic             job_take;
  mmcrc_pkg::job_t  job;

  mmcrc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .cfg_chan  (cfg_chan),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take)
  );

  mmcrc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_take  (job_take),
    .out_chan  (out_chan)
  );

endmodule
